[rtl/core/vvsa_pkg.sv]
// Shared widths, register map and reset values of the vital-sign averager.
package vvsa_pkg;

    localparam int IN_W   = 11;
    localparam int RATE_W = 9;
    localparam int SAT_W  = 8;
    localparam int OFS_W  = 5;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = ADDR_W - 2;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_RATE_LO  = 3'd0;
    localparam reg_idx_t REG_RATE_HI  = 3'd1;
    localparam reg_idx_t REG_SAT_LO   = 3'd2;
    localparam reg_idx_t REG_SAT_CEIL = 3'd3;
    localparam reg_idx_t REG_SAT_OFS  = 3'd4;

    localparam logic [RATE_W-1:0] RST_RATE_LO  = 9'd30;
    localparam logic [RATE_W-1:0] RST_RATE_HI  = 9'd180;
    localparam logic [SAT_W-1:0]  RST_SAT_LO   = 8'd70;
    localparam logic [SAT_W-1:0]  RST_SAT_CEIL = 8'd100;
    localparam logic [OFS_W-1:0]  RST_SAT_OFS  = 5'd4;

endpackage

[rtl/core/vvsa_serdiv.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module vvsa_serdiv #(
    parameter int DVD_W = 12,
    parameter int DVS_W = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVD_W-1:0]  quo_reg;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift the dividend out at the top while quotient bits enter at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/validated_vital_sign_averager_unit.sv]
// Top level of the validated vital-sign averager: ring store, walk sequencer and APB registers.
//
// Usage:
//   Input channel (s_valid/s_ready) takes one word per analysis window: a heart-rate and an
//   oxygen-saturation estimate, each with its own valid flag. Result channel (m_valid/m_ready)
//   delivers one word per input word: the mean of the in-range stored rates and saturations.
//   The APB port holds the five limit/offset registers; write them only while the block idles.
// Flow:
//   One word at a time. The walk reads each filled slot (ST_WALK_RD) and then adds it
//   (ST_WALK_ACC) through the single read port of the ring memory; the two means then pass in
//   turn through the shared one-bit-per-cycle divider, with SUM_W = 9 + clog2(RING_DEPTH+1) sum
//   bits (RING_DEPTH defaults to five). s_ready returns the cycle after the result is loaded.
// Reset:
//   aresetn (synchronous, active low) restores the default limits, empties the ring through its
//   per-slot valid bits (an unwritten slot reads as zero) and rewinds the write slot and fill count.
// Stalls:
//   The result sits in an output register. While m_ready stays low and a result is still held,
//   the sequencer parks in its final state and holds the next result; no input is taken meanwhile.
module validated_vital_sign_averager_unit #(
    parameter int RING_DEPTH = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [vvsa_pkg::IN_W-1:0]  s_rate_estimate,
    input  logic                              s_rate_ok,
    input  logic signed [vvsa_pkg::IN_W-1:0]  s_sat_estimate,
    input  logic                              s_sat_ok,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [vvsa_pkg::RATE_W-1:0]       m_shown_rate,
    output logic [vvsa_pkg::SAT_W-1:0]        m_shown_sat,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vvsa_pkg::ADDR_W-1:0]       paddr,
    input  logic [vvsa_pkg::DATA_W-1:0]       pwdata,
    output logic [vvsa_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int RATE_W    = vvsa_pkg::RATE_W;
    localparam int SAT_W     = vvsa_pkg::SAT_W;
    localparam int IN_W      = vvsa_pkg::IN_W;
    localparam int OFS_W     = vvsa_pkg::OFS_W;
    localparam int SLOT_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W     = $clog2(RING_DEPTH + 1);
    localparam int SUM_W     = RATE_W + CNT_W;
    localparam int SSUM_W    = SAT_W + CNT_W;
    localparam int WORD_W    = RATE_W + SAT_W;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_PREV     = 10'b00_0000_0010,
        ST_WRITE    = 10'b00_0000_0100,
        ST_WALK_RD  = 10'b00_0000_1000,
        ST_WALK_ACC = 10'b00_0001_0000,
        ST_RATE_GO  = 10'b00_0010_0000,
        ST_RATE_WT  = 10'b00_0100_0000,
        ST_SAT_GO   = 10'b00_1000_0000,
        ST_SAT_WT   = 10'b01_0000_0000,
        ST_DONE     = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RATE_W-1:0] rate_lo_reg;
    logic [RATE_W-1:0] rate_hi_reg;
    logic [SAT_W-1:0]  sat_lo_reg;
    logic [SAT_W-1:0]  sat_ceil_reg;
    logic [OFS_W-1:0]  sat_ofs_reg;

    vvsa_pkg::reg_idx_t cfg_idx;
    logic               cfg_wr;

    assign cfg_idx = paddr[vvsa_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_lo_reg  <= vvsa_pkg::RST_RATE_LO;
            rate_hi_reg  <= vvsa_pkg::RST_RATE_HI;
            sat_lo_reg   <= vvsa_pkg::RST_SAT_LO;
            sat_ceil_reg <= vvsa_pkg::RST_SAT_CEIL;
            sat_ofs_reg  <= vvsa_pkg::RST_SAT_OFS;
        end else if (cfg_wr) begin
            case (cfg_idx)
                vvsa_pkg::REG_RATE_LO:  rate_lo_reg  <= pwdata[RATE_W-1:0];
                vvsa_pkg::REG_RATE_HI:  rate_hi_reg  <= pwdata[RATE_W-1:0];
                vvsa_pkg::REG_SAT_LO:   sat_lo_reg   <= pwdata[SAT_W-1:0];
                vvsa_pkg::REG_SAT_CEIL: sat_ceil_reg <= pwdata[SAT_W-1:0];
                vvsa_pkg::REG_SAT_OFS:  sat_ofs_reg  <= pwdata[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            vvsa_pkg::REG_RATE_LO:  prdata = {{(vvsa_pkg::DATA_W-RATE_W){1'b0}}, rate_lo_reg};
            vvsa_pkg::REG_RATE_HI:  prdata = {{(vvsa_pkg::DATA_W-RATE_W){1'b0}}, rate_hi_reg};
            vvsa_pkg::REG_SAT_LO:   prdata = {{(vvsa_pkg::DATA_W-SAT_W){1'b0}}, sat_lo_reg};
            vvsa_pkg::REG_SAT_CEIL: prdata = {{(vvsa_pkg::DATA_W-SAT_W){1'b0}}, sat_ceil_reg};
            vvsa_pkg::REG_SAT_OFS:  prdata = {{(vvsa_pkg::DATA_W-OFS_W){1'b0}}, sat_ofs_reg};
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input qualification (signed estimate against unsigned limits)
    // ------------------------------------------------------------------
    logic             rate_in_fits;
    logic             sat_in_fits;
    logic             take_rate;
    logic             take_sat;
    logic [SAT_W:0]   sat_plus_ofs;
    logic [SAT_W-1:0] sat_corr;
    logic             accept;

    assign rate_in_fits = (s_rate_estimate > $signed({{(IN_W-RATE_W){1'b0}}, rate_lo_reg}))
                       && (s_rate_estimate < $signed({{(IN_W-RATE_W){1'b0}}, rate_hi_reg}));
    assign sat_in_fits  = (s_sat_estimate > $signed({{(IN_W-SAT_W){1'b0}}, sat_lo_reg}))
                       && (s_sat_estimate <= $signed({{(IN_W-SAT_W){1'b0}}, sat_ceil_reg}));
    assign take_rate    = s_rate_ok & rate_in_fits;
    assign take_sat     = s_sat_ok & sat_in_fits;

    // add the calibration offset, clamp at the ceiling
    assign sat_plus_ofs = {1'b0, s_sat_estimate[SAT_W-1:0]}
                        + {{(SAT_W+1-OFS_W){1'b0}}, sat_ofs_reg};
    assign sat_corr     = (sat_plus_ofs > {1'b0, sat_ceil_reg}) ? sat_ceil_reg
                                                                : sat_plus_ofs[SAT_W-1:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;

    // ------------------------------------------------------------------
    // Item and ring bookkeeping
    // ------------------------------------------------------------------
    logic              take_rate_reg;
    logic              take_sat_reg;
    logic [RATE_W-1:0] rate_new_reg;
    logic [SAT_W-1:0]  sat_new_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  filled_reg;
    logic [CNT_W-1:0]  idx_reg;

    logic [SLOT_W-1:0] prev_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic              have_fill;

    assign prev_slot = (slot_reg == '0) ? SLOT_W'(RING_DEPTH - 1) : slot_reg - 1'b1;
    assign rd_addr   = (state_reg == ST_PREV) ? prev_slot : idx_reg[SLOT_W-1:0];
    assign have_fill = (filled_reg != '0);

    always_ff @(posedge aclk) begin
        if (accept) begin
            take_rate_reg <= take_rate;
            take_sat_reg  <= take_sat;
            rate_new_reg  <= s_rate_estimate[RATE_W-1:0];
            sat_new_reg   <= sat_corr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= '0;
            filled_reg <= '0;
            idx_reg    <= '0;
        end else begin
            // the fill count moves on the rate decision, before the slot write looks at it
            if (accept && take_rate && (filled_reg < CNT_W'(RING_DEPTH))) begin
                filled_reg <= filled_reg + 1'b1;
            end
            if (state_reg == ST_WRITE) begin
                slot_reg <= (slot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                idx_reg  <= '0;
            end else if (state_reg == ST_WALK_ACC) begin
                idx_reg  <= idx_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Ring memory: {rate, sat} per slot, one write and one registered read
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]     ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] slot_vld_reg;
    logic [WORD_W-1:0]     rd_word_reg;
    logic                  rd_vld_reg;
    logic [WORD_W-1:0]     rd_data;
    logic [RATE_W-1:0]     rd_rate;
    logic [SAT_W-1:0]      rd_sat;
    logic                  mem_we;
    logic [RATE_W-1:0]     wr_rate;
    logic [SAT_W-1:0]      wr_sat;

    // an unwritten slot reads as its reset value of zero
    assign rd_data = rd_vld_reg ? rd_word_reg : '0;
    assign rd_rate = rd_data[WORD_W-1:SAT_W];
    assign rd_sat  = rd_data[SAT_W-1:0];

    // rejected values copy the previous slot once anything is filled; with nothing filled the
    // rate ring is still all zero, so a lone accepted saturation writes a zero rate beside it
    assign mem_we  = (state_reg == ST_WRITE) && (take_rate_reg || take_sat_reg || have_fill);
    assign wr_rate = take_rate_reg ? rate_new_reg : (have_fill ? rd_rate : '0);
    assign wr_sat  = take_sat_reg  ? sat_new_reg  : (have_fill ? rd_sat  : '0);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[slot_reg] <= {wr_rate, wr_sat};
        end
        rd_word_reg <= ring_mem[rd_addr];
        rd_vld_reg  <= slot_vld_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg <= '0;
        end else if (mem_we) begin
            slot_vld_reg[slot_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Walk: sum the entries that sit inside the current limits
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  rsum_reg;
    logic [SSUM_W-1:0] ssum_reg;
    logic [CNT_W-1:0]  rcnt_reg;
    logic [CNT_W-1:0]  scnt_reg;
    logic              rate_ok_walk;
    logic              sat_ok_walk;

    assign rate_ok_walk = (rd_rate > rate_lo_reg) && (rd_rate < rate_hi_reg);
    assign sat_ok_walk  = (rd_sat > sat_lo_reg) && (rd_sat <= sat_ceil_reg);

    always_ff @(posedge aclk) begin
        if (accept) begin
            rsum_reg <= '0;
            ssum_reg <= '0;
            rcnt_reg <= '0;
            scnt_reg <= '0;
        end else if (state_reg == ST_WALK_ACC) begin
            if (rate_ok_walk) begin
                rsum_reg <= rsum_reg + SUM_W'(rd_rate);
                rcnt_reg <= rcnt_reg + 1'b1;
            end
            if (sat_ok_walk) begin
                ssum_reg <= ssum_reg + SSUM_W'(rd_sat);
                scnt_reg <= scnt_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared divider: rate mean first, then saturation mean
    // ------------------------------------------------------------------
    logic             div_start;
    logic [SUM_W-1:0] div_dividend;
    logic [CNT_W-1:0] div_divisor;
    logic             div_done;
    logic [SUM_W-1:0] div_quotient;

    assign div_start    = (state_reg == ST_RATE_GO) || (state_reg == ST_SAT_GO);
    assign div_dividend = (state_reg == ST_SAT_GO) ? SUM_W'(ssum_reg) : rsum_reg;
    assign div_divisor  = (state_reg == ST_SAT_GO) ? scnt_reg : rcnt_reg;

    vvsa_serdiv #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    logic [RATE_W-1:0] rate_mean_reg;
    logic [SAT_W-1:0]  sat_mean_reg;

    // an empty count gives a mean of zero, whatever the divider made of it
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_RATE_WT) && div_done) begin
            rate_mean_reg <= (rcnt_reg == '0) ? '0 : div_quotient[RATE_W-1:0];
        end
        if ((state_reg == ST_SAT_WT) && div_done) begin
            sat_mean_reg  <= (scnt_reg == '0) ? '0 : div_quotient[SAT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic              m_valid_reg;
    logic [RATE_W-1:0] m_rate_reg;
    logic [SAT_W-1:0]  m_sat_reg;
    logic              out_load;

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_rate_reg <= rate_mean_reg;
            m_sat_reg  <= sat_mean_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_shown_rate = m_rate_reg;
    assign m_shown_sat  = m_sat_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_PREV;
            ST_PREV:     state_next = ST_WRITE;
            ST_WRITE:    state_next = have_fill ? ST_WALK_RD : ST_RATE_GO;
            ST_WALK_RD:  state_next = ST_WALK_ACC;
            ST_WALK_ACC: state_next = ((idx_reg + 1'b1) == filled_reg) ? ST_RATE_GO : ST_WALK_RD;
            ST_RATE_GO:  state_next = ST_RATE_WT;
            ST_RATE_WT:  if (div_done) state_next = ST_SAT_GO;
            ST_SAT_GO:   state_next = ST_SAT_WT;
            ST_SAT_WT:   if (div_done) state_next = ST_DONE;
            ST_DONE:     if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CNT_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(RING_DEPTH - 1))
        else $error("write slot beyond ring depth");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK_RD || state_reg == ST_WALK_ACC) |-> (idx_reg < filled_reg))
        else $error("walk index past filled slots");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside final state");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_RATE_WT || state_reg == ST_SAT_WT))
        else $error("divider finished while sequencer not waiting");

endmodule

[dv/validated_vital_sign_averager_unit_tb.sv]
// Self-checking testbench for the validated vital-sign averager: APB limits, window words, means.
`timescale 1ns / 100ps

module validated_vital_sign_averager_unit_tb;

    localparam int IN_W   = vvsa_pkg::IN_W;
    localparam int RATE_W = vvsa_pkg::RATE_W;
    localparam int SAT_W  = vvsa_pkg::SAT_W;
    localparam int OFS_W  = vvsa_pkg::OFS_W;
    localparam int ADDR_W = vvsa_pkg::ADDR_W;
    localparam int DATA_W = vvsa_pkg::DATA_W;
    localparam int IDX_W  = vvsa_pkg::IDX_W;

    localparam int DEPTH        = 5;
    // covers the worst-case processing of one word; leave a margin on top
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // one window word as offered on the input channel
    typedef struct packed {
        logic [IN_W-1:0] rate;
        logic            rate_ok;
        logic [IN_W-1:0] sat;
        logic            sat_ok;
    } window_t;

    // the two means that one window word should produce
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [SAT_W-1:0]  sat;
    } window_means_t;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                   aclk            = 1'b0;
    logic                   aresetn         = 1'b0;
    logic                   s_valid         = 1'b0;
    logic                   s_ready;
    logic [IN_W-1:0]        s_rate_estimate = '0;
    logic                   s_rate_ok       = 1'b0;
    logic [IN_W-1:0]        s_sat_estimate  = '0;
    logic                   s_sat_ok        = 1'b0;
    logic                   m_valid;
    logic                   m_ready         = 1'b0;
    logic [RATE_W-1:0]      m_shown_rate;
    logic [SAT_W-1:0]       m_shown_sat;
    logic                   psel            = 1'b0;
    logic                   penable         = 1'b0;
    logic                   pwrite          = 1'b0;
    logic [ADDR_W-1:0]      paddr           = '0;
    logic [DATA_W-1:0]      pwdata          = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    validated_vital_sign_averager_unit #(
        .RING_DEPTH (DEPTH)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rate_estimate (s_rate_estimate),
        .s_rate_ok       (s_rate_ok),
        .s_sat_estimate  (s_sat_estimate),
        .s_sat_ok        (s_sat_ok),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_shown_rate    (m_shown_rate),
        .m_shown_sat     (m_shown_sat),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: limits as last written, ring contents and pointers
    // ------------------------------------------------------------------
    logic [RATE_W-1:0] rate_lo  = vvsa_pkg::RST_RATE_LO;
    logic [RATE_W-1:0] rate_hi  = vvsa_pkg::RST_RATE_HI;
    logic [SAT_W-1:0]  sat_lo   = vvsa_pkg::RST_SAT_LO;
    logic [SAT_W-1:0]  sat_ceil = vvsa_pkg::RST_SAT_CEIL;
    logic [OFS_W-1:0]  sat_ofs  = vvsa_pkg::RST_SAT_OFS;

    logic [RATE_W-1:0] rate_ring [DEPTH] = '{default: '0};
    logic [SAT_W-1:0]  sat_ring  [DEPTH] = '{default: '0};
    int                write_slot   = 0;
    int                filled_slots = 0;

    window_t           pending_windows [$];
    window_means_t     expected_means  [$];

    int  mismatch_count    = 0;
    int  words_sent        = 0;
    int  means_checked     = 0;
    int  nonzero_rate_mean = 0;
    int  nonzero_sat_mean  = 0;
    int  limit_settings    = 0;
    int  register_writes   = 0;
    int  cycle_count       = 0;
    int  tx_gap_left       = 0;
    int  rx_hold_left      = 0;
    int  long_holds_asked  = 0;
    int  long_holds_served = 0;
    bit  tx_gaps_on        = 1'b1;
    bit  rx_gaps_on        = 1'b1;

    function automatic bit rate_in_limits(input int r);
        int lo, hi;
        lo = int'(rate_lo);
        hi = int'(rate_hi);
        return (r > lo) && (r < hi);
    endfunction

    function automatic bit sat_in_limits(input int s);
        int lo, ceil_v;
        lo     = int'(sat_lo);
        ceil_v = int'(sat_ceil);
        return (s > lo) && (s <= ceil_v);
    endfunction

    // Fold one accepted window into the shadow rings and queue the two means it must give.
    task automatic average_window(input window_t w);
        int            rate_v, sat_v, slot, prev, corr;
        int            rsum, rcnt, ssum, scnt;
        window_means_t m;
        rate_v = $signed(w.rate);
        sat_v  = $signed(w.sat);
        slot   = write_slot;
        prev   = (slot == 0) ? DEPTH - 1 : slot - 1;

        // rate first: the fill count it bumps already governs the saturation copy below
        if (w.rate_ok && rate_in_limits(rate_v)) begin
            rate_ring[slot] = rate_v[RATE_W-1:0];
            if (filled_slots < DEPTH)
                filled_slots++;
        end else if (filled_slots > 0) begin
            rate_ring[slot] = rate_ring[prev];
        end

        if (w.sat_ok && sat_in_limits(sat_v)) begin
            corr = sat_v + int'(sat_ofs);
            if (corr > int'(sat_ceil))
                corr = int'(sat_ceil);
            sat_ring[slot] = corr[SAT_W-1:0];
        end else if (filled_slots > 0) begin
            sat_ring[slot] = sat_ring[prev];
        end

        write_slot = (slot + 1) % DEPTH;

        rsum = 0; rcnt = 0; ssum = 0; scnt = 0;
        for (int i = 0; i < filled_slots; i++) begin
            if (rate_in_limits(int'(rate_ring[i]))) begin
                rsum += int'(rate_ring[i]);
                rcnt++;
            end
            if (sat_in_limits(int'(sat_ring[i]))) begin
                ssum += int'(sat_ring[i]);
                scnt++;
            end
        end
        m.rate = (rcnt > 0) ? RATE_W'(rsum / rcnt) : '0;
        m.sat  = (scnt > 0) ? SAT_W'(ssum / scnt) : '0;
        if (m.rate != 0) nonzero_rate_mean++;
        if (m.sat != 0)  nonzero_sat_mean++;
        expected_means.push_back(m);
    endtask

    // Mostly zero, sometimes a short gap, rarely a long one.
    function automatic int draw_gap(input bit enabled);
        int roll;
        roll = $urandom_range(99);
        if (!enabled || roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(4, 1);
        return $urandom_range(80, 20);
    endfunction

    // Pick an estimate: mostly inside (lo_excl, hi_excl), some on its edges, some raw 11-bit noise.
    function automatic logic [IN_W-1:0] pick_estimate(input int lo_excl, input int hi_excl);
        int roll, v;
        roll = $urandom_range(99);
        if (roll < 60 && hi_excl - lo_excl >= 2) begin
            v = $urandom_range(hi_excl - 1, lo_excl + 1);
        end else if (roll < 82) begin
            case ($urandom_range(3))
                0: v = lo_excl;
                1: v = lo_excl + 1;
                2: v = hi_excl - 1;
                default: v = hi_excl;
            endcase
        end else begin
            v = $urandom_range(2047);
        end
        return v[IN_W-1:0];
    endfunction

    function automatic window_t random_window();
        window_t w;
        w.rate_ok = ($urandom_range(99) < 85);
        w.sat_ok  = ($urandom_range(99) < 85);
        w.rate    = pick_estimate(int'(rate_lo), int'(rate_hi));
        w.sat     = pick_estimate(int'(sat_lo), int'(sat_ceil) + 1);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: predict on every accepted word, then offer the next
    // pending word or idle for the drawn gap
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : window_driver
        window_t nxt;
        bit      taken;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            tx_gap_left = 0;
        end else begin
            taken = s_valid && s_ready;
            if (taken) begin
                average_window({s_rate_estimate, s_rate_ok, s_sat_estimate, s_sat_ok});
                words_sent++;
            end
            // hold valid and payload until the word is taken
            if (!s_valid || taken) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_windows.size() != 0) begin
                    nxt             = pending_windows.pop_front();
                    s_rate_estimate <= nxt.rate;
                    s_rate_ok       <= nxt.rate_ok;
                    s_sat_estimate  <= nxt.sat;
                    s_sat_ok        <= nxt.sat_ok;
                    s_valid         <= 1'b1;
                    tx_gap_left     = draw_gap(tx_gaps_on);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side ready: short random stalls, plus a long hold-off on request
    // so the block parks with a result held and stops taking input
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_ready_gen
        if (!aresetn) begin
            m_ready      <= 1'b0;
            rx_hold_left = 0;
        end else begin
            if (rx_hold_left > 0)
                rx_hold_left--;
            else if (m_valid && m_ready)
                rx_hold_left = draw_gap(rx_gaps_on);
            else if (rx_gaps_on && $urandom_range(15) == 0)
                rx_hold_left = draw_gap(1'b1);
            if (long_holds_served != long_holds_asked) begin
                rx_hold_left      = LONG_HOLD;
                long_holds_served = long_holds_asked;
            end
            m_ready <= (rx_hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken word with the oldest expected means
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        window_means_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_means.size() == 0) begin
                $display("%0t: unexpected result word, rate %0d sat %0d",
                         $time, m_shown_rate, m_shown_sat);
                mismatch_count++;
            end else begin
                want = expected_means.pop_front();
                means_checked++;
                if (m_shown_rate !== want.rate) begin
                    $display("%0t: shown_rate expected %0d, got %0d",
                             $time, want.rate, m_shown_rate);
                    mismatch_count++;
                end
                if (m_shown_sat !== want.sat) begin
                    $display("%0t: shown_sat expected %0d, got %0d",
                             $time, want.sat, m_shown_sat);
                    mismatch_count++;
                end
            end
        end
    end

    // bound the run in case the block hangs
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: no finish after %0d cycles, %0d words still expected",
                     $time, cycle_count, expected_means.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register over APB, then read it back (mapped registers only).
    task automatic write_register(input vvsa_pkg::reg_idx_t idx,
                                  input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] want;
        bit                mapped;
        mapped = 1'b1;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // the write lands on this edge; mirror it and go straight to the read setup
        case (idx)
            vvsa_pkg::REG_RATE_LO:  rate_lo  = value[RATE_W-1:0];
            vvsa_pkg::REG_RATE_HI:  rate_hi  = value[RATE_W-1:0];
            vvsa_pkg::REG_SAT_LO:   sat_lo   = value[SAT_W-1:0];
            vvsa_pkg::REG_SAT_CEIL: sat_ceil = value[SAT_W-1:0];
            vvsa_pkg::REG_SAT_OFS:  sat_ofs  = value[OFS_W-1:0];
            default:                mapped   = 1'b0;
        endcase
        register_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (mapped) begin
            case (idx)
                vvsa_pkg::REG_RATE_LO:  want = DATA_W'(rate_lo);
                vvsa_pkg::REG_RATE_HI:  want = DATA_W'(rate_hi);
                vvsa_pkg::REG_SAT_LO:   want = DATA_W'(sat_lo);
                vvsa_pkg::REG_SAT_CEIL: want = DATA_W'(sat_ceil);
                default:                want = DATA_W'(sat_ofs);
            endcase
            if (prdata !== want) begin
                $display("%0t: readback of register %0d expected %0d, got %0d",
                         $time, idx, want, prdata);
                mismatch_count++;
            end
        end
    endtask

    // Now and then set junk above the register width; the block must drop it.
    function automatic logic [DATA_W-1:0] with_noise(input int v, input int w);
        logic [DATA_W-1:0] mask;
        mask = (DATA_W'(1) << w) - 1;
        if ($urandom_range(3) == 0)
            return ($urandom & ~mask) | (DATA_W'(v) & mask);
        return DATA_W'(v) & mask;
    endfunction

    task automatic apply_limits(input int rlo, input int rhi, input int slo,
                                input int sceil, input int sofs);
        write_register(vvsa_pkg::REG_RATE_LO,  with_noise(rlo, RATE_W));
        write_register(vvsa_pkg::REG_RATE_HI,  with_noise(rhi, RATE_W));
        write_register(vvsa_pkg::REG_SAT_LO,   with_noise(slo, SAT_W));
        write_register(vvsa_pkg::REG_SAT_CEIL, with_noise(sceil, SAT_W));
        write_register(vvsa_pkg::REG_SAT_OFS,  with_noise(sofs, OFS_W));
        limit_settings++;
    endtask

    task automatic push_window(input int r, input bit rok, input int s, input bit sok);
        window_t w;
        w.rate    = r[IN_W-1:0];
        w.rate_ok = rok;
        w.sat     = s[IN_W-1:0];
        w.sat_ok  = sok;
        pending_windows.push_back(w);
    endtask

    // Wait until nothing is pending or in flight.
    task automatic wait_for_idle();
        while (pending_windows.size() != 0 || s_valid || expected_means.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Random words in bursts; gaps switch on and off per burst, and the sender
    // sometimes pauses until every result is back.
    task automatic run_phase(input int n_items, input bit long_hold);
        int left, burst;
        left = n_items;
        if (long_hold) begin
            // keep offering words while the receiver sits on its hands
            tx_gaps_on = 1'b0;
            burst      = (left < 12) ? left : 12;
            repeat (burst) pending_windows.push_back(random_window());
            left -= burst;
            long_holds_asked++;
            while (pending_windows.size() != 0)
                @(posedge aclk);
        end
        while (left > 0) begin
            burst = $urandom_range(20, 4);
            if (burst > left)
                burst = left;
            tx_gaps_on = ($urandom_range(3) != 0);
            rx_gaps_on = ($urandom_range(3) != 0);
            repeat (burst) pending_windows.push_back(random_window());
            left -= burst;
            while (pending_windows.size() != 0)
                @(posedge aclk);
            if ($urandom_range(9) < 3)
                wait_for_idle();
        end
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int rlo, rhi, slo, sceil, sofs;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset limits (rate 30..180, sat 70..100, offset 4).
        // Nothing stored yet: the rejected rate writes a zero beside the accepted sat, both means stay 0.
        push_window(100, 1'b0, 90, 1'b1);
        // first accepted rate with a rejected saturation: copy of the saturation the first word stored
        push_window(31, 1'b1, -1024, 1'b1);
        push_window(30, 1'b1, 70, 1'b1);          // both exactly on the lower limit
        push_window(179, 1'b1, 71, 1'b1);         // just inside both
        push_window(180, 1'b1, 100, 1'b1);        // rate on upper limit, sat clamps at ceiling
        push_window(-1024, 1'b1, 97, 1'b1);       // slot 0 again: copy from the last slot
        push_window(1023, 1'b1, 1023, 1'b1);
        push_window(-1, 1'b1, -1, 1'b1);
        push_window(150, 1'b0, 80, 1'b0);         // in range but flagged invalid
        push_window(511, 1'b1, 255, 1'b1);
        push_window(512, 1'b1, 256, 1'b1);
        push_window(0, 1'b1, 0, 1'b1);
        push_window(60, 1'b1, 98, 1'b1);
        push_window(120, 1'b1, 88, 1'b1);
        push_window(170, 1'b1, 75, 1'b1);
        push_window(45, 1'b1, 72, 1'b1);
        push_window(99, 1'b1, 96, 1'b1);
        push_window(-700, 1'b0, 600, 1'b0);
        wait_for_idle();

        // widest limits and the largest offset
        apply_limits(0, 511, 0, 255, 31);
        run_phase(60, 1'b0);

        // crossed and empty limits: nothing accepted, every mean 0
        apply_limits(511, 0, 255, 0, 0);
        run_phase(25, 1'b0);

        // a single accepted value on each side
        apply_limits(59, 61, 97, 98, 0);
        run_phase(40, 1'b0);

        // back to reset values with the largest offset; long receiver hold-off here
        apply_limits(int'(vvsa_pkg::RST_RATE_LO), int'(vvsa_pkg::RST_RATE_HI),
                     int'(vvsa_pkg::RST_SAT_LO), int'(vvsa_pkg::RST_SAT_CEIL), 31);
        run_phase(70, 1'b1);

        // unmapped register addresses must not disturb anything
        for (int k = int'(vvsa_pkg::REG_SAT_OFS) + 1; k < (1 << IDX_W); k++)
            write_register(vvsa_pkg::reg_idx_t'(k), $urandom);
        run_phase(40, 1'b0);

        // random settings, mostly sensible, sometimes anything
        repeat (5) begin
            if ($urandom_range(3) == 0) begin
                rlo   = $urandom_range(511);
                rhi   = $urandom_range(511);
                slo   = $urandom_range(255);
                sceil = $urandom_range(255);
            end else begin
                rlo   = $urandom_range(120);
                rhi   = rlo + $urandom_range(300);
                slo   = $urandom_range(90);
                sceil = slo + $urandom_range(60, 1);
                if (rhi > 511)   rhi   = 511;
                if (sceil > 255) sceil = 255;
            end
            sofs = $urandom_range(31);
            apply_limits(rlo, rhi, slo, sceil, sofs);
            run_phase(60, 1'b0);
        end

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d window words over %0d limit settings (%0d register writes), %0d checked.",
                 words_sent, limit_settings, register_writes, means_checked);
        $display("Nonzero means: rate %0d, saturation %0d; one %0d-cycle result hold-off.",
                 nonzero_rate_mean, nonzero_sat_mean, LONG_HOLD);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
